>>> rtl/windowed_pid_speed_controller_top_macros.svh
// Assertion macros for the windowed PID speed controller.
// Used by the top level only; depends on nothing else.
`ifndef WINDOWED_PID_SPEED_CONTROLLER_TOP_MACROS_SVH
`define WINDOWED_PID_SPEED_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define WPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define WPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define WPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/wpid_pkg.sv
// Shared constants and types for the windowed PID speed controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package wpid_pkg;
    localparam int WINDOW   = 10;
    localparam int WARMUP   = 6;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int WAIT_W   = $clog2(WINDOW + 3);
    localparam int ERR_W    = 24;
    localparam int STAMP_W  = 32;
    localparam int NUM_W    = 43;
    localparam int DEN_W    = 33;
    localparam logic [31:0] MPH_Q16  = 32'd146600;
    localparam logic [95:0] TERM_LIM = 96'd1 << 61;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_PROP  = 2'd0;
    localparam logic [1:0] REG_INTEG = 2'd1;
    localparam logic [1:0] REG_DERIV = 2'd2;

    // One window entry as handed from cell to cell.
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [STAMP_W-1:0]      stamp;
    } t_entry;
endpackage

>>> rtl/wpid_cell.sv
// One window cell: holds an error and its stamp, forms the trapezoid term
// with its older neighbour and adds it into the running sum. Uses wpid_pkg.
`timescale 1ns / 1ps
module wpid_cell import wpid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_shift,
    input  t_entry              i_entry,
    input  t_entry              i_older,
    input  logic                i_pair_en,
    input  logic signed [63:0]  i_psum,
    output t_entry              o_entry,
    output logic signed [63:0]  o_psum
);
    t_entry             r_entry;
    logic signed [63:0] r_term;
    logic signed [63:0] r_psum;
    logic signed [24:0] w_esum;
    logic signed [32:0] w_dt;
    logic signed [57:0] w_prod;

    // The trapezoid term of this entry and the next older one.
    assign w_esum = {r_entry.err[ERR_W-1], r_entry.err} + {i_older.err[ERR_W-1], i_older.err};
    assign w_dt   = $signed({1'b0, r_entry.stamp}) - $signed({1'b0, i_older.stamp});
    assign w_prod = w_esum * w_dt;

    // Entry storage, masked term and the sum handed to the newer neighbour.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
        r_term <= i_pair_en ? {{6{w_prod[57]}}, w_prod} : 64'sd0;
        r_psum <= r_term + i_psum;
    end

    assign o_entry = r_entry;
    assign o_psum  = r_psum;
endmodule

>>> rtl/wpid_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Uses wpid_pkg for its widths.
`timescale 1ns / 1ps
module wpid_div import wpid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0]  o_quo,
    output logic              o_done
);
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_rem_sh;
    logic             w_fit;

    // One trial subtraction of the shifted remainder.
    assign w_rem_sh = {r_rem, r_q[NUM_W-1]};
    assign w_fit    = w_rem_sh >= {1'b0, r_den};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_fit};
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;
endmodule

>>> rtl/windowed_pid_speed_controller_top.sv
// Windowed PID speed controller, one item at a time; an item passes the 24-step
// square root, the 43-step derivative divider and the gain products, then its
// result is offered. Items inside warm-up finish after the square root.
// Synchronous active-low reset clears the gains, fill count and control state.
`timescale 1ns / 1ps
`include "windowed_pid_speed_controller_top_macros.svh"
module windowed_pid_speed_controller_top import wpid_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [23:0]  i_vel_x,
    input  logic signed [23:0]  i_vel_y,
    input  logic signed [23:0]  i_vel_z,
    input  logic [31:0]         i_stamp,
    input  logic [15:0]         i_setpoint_mph,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_drive,
    output logic                o_ready_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_MPH, S_SHIFT, S_DSET, S_DIV, S_SUMW, S_MUL, S_OUT
    } t_state;

    t_state              r_state;
    logic signed [31:0]  r_kp, r_ki, r_kd;
    logic [23:0]         r_mag [3];
    logic [31:0]         r_stamp;
    logic [15:0]         r_sp;
    logic [5:0]          r_cnt;
    logic [47:0]         r_rad;
    logic [25:0]         r_rem;
    logic [23:0]         r_root;
    logic [63:0]         r_prod;
    logic signed [23:0]  r_err;
    logic [FILL_W-1:0]   r_fill;
    logic [WAIT_W-1:0]   r_wait;
    logic                r_dneg;
    logic                r_dzero;
    logic [1:0]          r_tsel;
    logic [2:0]          r_mc;
    logic [95:0]         r_big;
    logic signed [63:0]  r_total;
    logic signed [31:0]  r_drive;
    logic                r_ready_res;

    logic [31:0]         w_op_a, w_op_b;
    logic [27:0]         w_rem_sh, w_trial;
    logic [42:0]         w_mph_rnd;
    logic signed [28:0]  w_err_full;
    logic [FILL_W-1:0]   n_fill;
    logic signed [24:0]  w_de;
    logic signed [32:0]  w_dt;
    logic [NUM_W-1:0]    w_quo;
    logic                w_div_done;
    logic signed [43:0]  w_deriv;
    logic signed [31:0]  w_gain;
    logic signed [63:0]  w_bval;
    logic [63:0]         w_bmag;
    logic [31:0]         w_gmag;
    logic                w_tneg;
    logic [95:0]         w_round, w_shq;
    logic [63:0]         w_qmag;
    logic signed [63:0]  n_total;
    logic signed [63:0]  w_psum0;

    t_entry              w_entry [WINDOW+1];
    logic signed [63:0]  w_psum  [WINDOW+1];

    // Window chain: cell 0 holds the newest sample.
    assign w_entry[WINDOW] = '0;
    assign w_psum[WINDOW]  = 64'sd0;
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        t_entry w_in;
        assign w_in = (k == 0) ? t_entry'{err: r_err, stamp: r_stamp} : w_entry[(k == 0) ? 0 : k-1];
        wpid_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (r_state == S_SHIFT),
            .i_entry   (w_in),
            .i_older   (w_entry[k+1]),
            .i_pair_en ((k < WINDOW - 1) && (FILL_W'(k + 1) < r_fill)),
            .i_psum    (w_psum[k+1]),
            .o_entry   (w_entry[k]),
            .o_psum    (w_psum[k])
        );
    end
    assign w_psum0 = w_psum[0];

    // Shared 32x32 multiplier operands.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_SQ: begin
                w_op_a = {8'd0, r_mag[r_cnt[1:0] == 2'd3 ? 2'd0 : r_cnt[1:0]]};
                w_op_b = w_op_a;
            end
            S_MPH: begin
                w_op_a = {8'd0, r_root};
                w_op_b = MPH_Q16;
            end
            S_MUL: begin
                w_op_a = w_gmag;
                w_op_b = (r_mc == 3'd0) ? w_bmag[31:0] : w_bmag[63:32];
            end
            default: ;
        endcase
    end

    // Square root step, mph rounding and error saturation.
    assign w_rem_sh   = {r_rem, r_rad[47:46]};
    assign w_trial    = {2'b00, r_root, 2'b01};
    assign w_mph_rnd  = r_prod[42:0] + 43'd32768;
    assign w_err_full = $signed({13'd0, r_sp}) - $signed({2'd0, w_mph_rnd[42:16]});
    assign n_fill     = (r_fill < FILL_W'(WINDOW)) ? r_fill + 1'b1 : r_fill;

    // Derivative operands from the two newest cells.
    assign w_de = {w_entry[0].err[23], w_entry[0].err} - {w_entry[1].err[23], w_entry[1].err};
    assign w_dt = $signed({1'b0, w_entry[0].stamp}) - $signed({1'b0, w_entry[1].stamp});

    wpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSET),
        .i_num   ({(w_de[24] ? 25'(-w_de) : 25'(w_de)), 18'd0}),
        .i_den   (w_dt[32] ? 33'(-w_dt) : 33'(w_dt)),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_deriv = r_dzero ? 44'sd0 : (r_dneg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo}));

    // Operands of the current gain product.
    always_comb begin
        case (r_tsel)
            2'd0:    begin w_gain = r_kp; w_bval = 64'(r_err);   end
            2'd1:    begin w_gain = r_ki; w_bval = w_psum0;      end
            default: begin w_gain = r_kd; w_bval = 64'(w_deriv); end
        endcase
        w_gmag = w_gain[31] ? 32'(-w_gain) : 32'(w_gain);
        w_bmag = w_bval[63] ? 64'(-w_bval) : 64'(w_bval);
        w_tneg = w_gain[31] ^ w_bval[63];
        case (r_tsel)
            2'd0:    begin w_round = 96'd1 << 7;  w_shq = r_big >> 8;  end
            2'd1:    begin w_round = 96'd1 << 18; w_shq = r_big >> 19; end
            default: begin w_round = 96'd1 << 15; w_shq = r_big >> 16; end
        endcase
        w_qmag  = (w_shq > TERM_LIM) ? TERM_LIM[63:0] : w_shq[63:0];
        n_total = w_tneg ? r_total - $signed(w_qmag) : r_total + $signed(w_qmag);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP:  r_kp <= i_cfg_data;
                REG_INTEG: r_ki <= i_cfg_data;
                REG_DERIV: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with its datapath registers and the registered result.
    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * w_op_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wait      <= '0;
            r_drive     <= '0;
            r_ready_res <= 1'b0;
        end else begin
            // The settle counter restarts when a new entry enters the chain.
            if (r_state == S_SHIFT) begin
                r_wait <= '0;
            end else if (r_wait != WAIT_W'(WINDOW + 2)) begin
                r_wait <= r_wait + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mag[0] <= i_vel_x[23] ? 24'(-i_vel_x) : 24'(i_vel_x);
                        r_mag[1] <= i_vel_y[23] ? 24'(-i_vel_y) : 24'(i_vel_y);
                        r_mag[2] <= i_vel_z[23] ? 24'(-i_vel_z) : 24'(i_vel_z);
                        r_stamp  <= i_stamp;
                        r_sp     <= i_setpoint_mph;
                        r_rad    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt != 6'd0) begin
                        r_rad <= r_rad + r_prod[47:0];
                    end
                    if (r_cnt == 6'd3) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= 26'(w_rem_sh - w_trial);
                        r_root <= {r_root[22:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh[25:0];
                        r_root <= {r_root[22:0], 1'b0};
                    end
                    r_rad <= {r_rad[45:0], 2'b00};
                    if (r_cnt == 6'd23) begin
                        r_cnt   <= '0;
                        r_state <= S_MPH;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_MPH: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd1) begin
                        if (w_err_full < -29'sd8388608) begin
                            r_err <= -24'sd8388608;
                        end else if (w_err_full > 29'sd8388607) begin
                            r_err <= 24'sd8388607;
                        end else begin
                            r_err <= w_err_full[23:0];
                        end
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_fill <= n_fill;
                    if (n_fill < FILL_W'(WARMUP) || WARMUP > WINDOW) begin
                        r_drive     <= '0;
                        r_ready_res <= 1'b0;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_dneg  <= w_de[24] ^ w_dt[32];
                    r_dzero <= (w_dt == 33'sd0);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_SUMW;
                    end
                end
                S_SUMW: begin
                    if (r_wait == WAIT_W'(WINDOW + 2)) begin
                        r_tsel  <= 2'd0;
                        r_mc    <= '0;
                        r_total <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mc == 3'd4) begin
                        r_mc <= '0;
                    end else begin
                        r_mc <= r_mc + 3'd1;
                    end
                    case (r_mc)
                        3'd1: r_big <= {32'd0, r_prod};
                        3'd2: r_big <= r_big + {r_prod, 32'd0};
                        3'd3: r_big <= r_big + w_round;
                        3'd4: begin
                            r_total <= n_total;
                            if (r_tsel == 2'd2) begin
                                if (n_total > 64'sd2147483647) begin
                                    r_drive <= 32'sh7fffffff;
                                end else if (n_total < -64'sd2147483648) begin
                                    r_drive <= 32'sh80000000;
                                end else begin
                                    r_drive <= n_total[31:0];
                                end
                                r_ready_res <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_tsel <= r_tsel + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_drive     = r_drive;
    assign o_ready_res = r_ready_res;

    // A result during warm-up carries zero drive.
    `WPID_ASSERT_NOW(a_warmup_zero, i_clk, i_rst_n, o_valid && !o_ready_res, o_drive == 32'sd0)
    // The fill count never passes the window length.
    `WPID_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(WINDOW))
    // An accepted item leaves the input side closed until its result is gone.
    `WPID_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)
endmodule

>>> sim/windowed_pid_speed_controller_checker.sv
// Checker for the windowed PID speed controller: predicts drive and readiness
// from each accepted item and compares them with the result items. Uses wpid_pkg.
`timescale 1ns / 1ps
module windowed_pid_speed_controller_checker import wpid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [23:0] i_vel_x,
    input  logic signed [23:0] i_vel_y,
    input  logic signed [23:0] i_vel_z,
    input  logic [31:0]        i_stamp,
    input  logic [15:0]        i_setpoint_mph,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_drive,
    input  logic               i_ready_res,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct {
        logic signed [31:0] drive;
        logic               ready_res;
    } t_drive_result;

    t_drive_result drive_queue[$];
    longint gain_p, gain_i, gain_d;
    longint err_ring[WINDOW];
    longint stamp_ring[WINDOW];
    int held, slot;

    assign o_pending = drive_queue.size();

    // Floor square root by bit pairs.
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scaled product, rounded half away from zero, clamped to 2^61.
    function automatic longint scaled_term(longint a, longint b, int sh);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(signed'(a)) * 128'(signed'(b));
        m = p < 0 ? -p : p;
        m = (m + (128'd1 << (sh - 1))) >> sh;
        if (m > (128'd1 << 61)) m = 128'd1 << 61;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Works out the result of one accepted item and updates the window.
    function automatic t_drive_result predict_drive(longint vx, longint vy, longint vz,
                                                    longint st, longint sp);
        t_drive_result r;
        longint unsigned speed;
        longint mph, e, sum, de, dt, deriv, total;
        int base, i0, i1;
        speed = root_floor(longint'(vx * vx + vy * vy + vz * vz));
        mph = longint'((speed * 146600 + 32768) >> 16);
        e = sp - mph;
        if (e < -8388608) e = -8388608;
        if (e > 8388607) e = 8388607;
        err_ring[slot] = e;
        stamp_ring[slot] = st;
        slot = (slot + 1) % WINDOW;
        if (held < WINDOW) held++;
        r.drive = 0;
        r.ready_res = 0;
        if (held >= WARMUP) begin
            base = (slot + WINDOW - held) % WINDOW;
            sum = 0;
            de = 0;
            dt = 0;
            deriv = 0;
            for (int k = 0; k + 1 < held; k++) begin
                i0 = (base + k) % WINDOW;
                i1 = (base + k + 1) % WINDOW;
                de = err_ring[i1] - err_ring[i0];
                dt = stamp_ring[i1] - stamp_ring[i0];
                sum += (err_ring[i0] + err_ring[i1]) * dt;
            end
            if (dt != 0) deriv = (de * 262144) / dt;
            total = scaled_term(gain_p, e, 8) + scaled_term(gain_i, sum, 19)
                  + scaled_term(gain_d, deriv, 16);
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            if (total < -64'sd2147483648) total = -64'sd2147483648;
            r.drive = total[31:0];
            r.ready_res = 1'b1;
        end
        return r;
    endfunction

    // Watches configuration writes and both channels.
    always @(posedge i_clk) begin
        t_drive_result exp_res;
        int fails;
        fails = 0;
        if (!i_rst_n) begin
            gain_p <= 0;
            gain_i <= 0;
            gain_d <= 0;
            held = 0;
            slot = 0;
            o_fail_count <= 0;
            drive_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROP:  gain_p <= longint'(signed'(i_cfg_data));
                    REG_INTEG: gain_i <= longint'(signed'(i_cfg_data));
                    REG_DERIV: gain_d <= longint'(signed'(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                drive_queue.insert(drive_queue.size(),
                                   predict_drive(i_vel_x, i_vel_y, i_vel_z,
                                                 {32'd0, i_stamp}, {48'd0, i_setpoint_mph}));
            if (i_out_valid && i_out_ready) begin
                if (drive_queue.size() == 0) begin
                    $error("result item with none expected");
                    fails++;
                end else begin
                    exp_res = drive_queue.pop_front();
                    if (i_drive !== exp_res.drive) begin
                        $error("drive: expected %0d, got %0d", exp_res.drive, i_drive);
                        fails++;
                    end
                    if (i_ready_res !== exp_res.ready_res) begin
                        $error("ready_res: expected %0d, got %0d", exp_res.ready_res,
                               i_ready_res);
                        fails++;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
        end
    end
endmodule

>>> sim/windowed_pid_speed_controller_top_test.sv
// Testbench top for the windowed PID speed controller: drives samples and gain
// writes, stalls the output, and gives the verdict. Uses wpid_pkg and the checker.
`timescale 1ns / 1ps
module windowed_pid_speed_controller_top_test;
    import wpid_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_PROP;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [23:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic [31:0] stamp = '0;
    logic [15:0] setpoint = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] drive;
    logic ready_res;
    int fail_count, pending;
    logic long_hold = 1'b0;
    logic [31:0] clock_stamp = '0;

    always #6 clk = ~clk;

    windowed_pid_speed_controller_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_ready(in_ready),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z), .i_stamp(stamp),
        .i_setpoint_mph(setpoint), .o_valid(out_valid), .i_ready(out_ready),
        .o_drive(drive), .o_ready_res(ready_res)
    );

    windowed_pid_speed_controller_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z), .i_stamp(stamp),
        .i_setpoint_mph(setpoint), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_drive(drive), .i_ready_res(ready_res), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Receiver stalls on its own pattern, with quiet stretches and one long hold.
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            if (long_hold) out_ready <= 1'b0;
            else if (mode == 0) out_ready <= 1'b1;
            else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
            else out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Writes one gain register while the block is idle.
    task automatic write_gain(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one sample and holds it until accepted.
    task automatic send_sample(input logic [23:0] x, input logic [23:0] y,
                               input logic [23:0] z, input logic [31:0] st,
                               input logic [15:0] sp);
        vel_x <= x;
        vel_y <= y;
        vel_z <= z;
        stamp <= st;
        setpoint <= sp;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random sample: mostly moderate speeds and advancing time, sometimes extremes.
    task automatic send_random;
        logic [23:0] x, y, z;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            x = 24'($signed($urandom_range(0, 16000)) - 8000);
            y = 24'($signed($urandom_range(0, 16000)) - 8000);
            z = 24'($signed($urandom_range(0, 2000)) - 1000);
        end else begin
            x = 24'($urandom);
            y = 24'($urandom);
            z = 24'($urandom);
        end
        kind = $urandom_range(0, 19);
        if (kind == 0) clock_stamp = clock_stamp;
        else if (kind == 1) clock_stamp = clock_stamp - $urandom_range(1, 100);
        else if (kind == 2) clock_stamp = $urandom;
        else clock_stamp = clock_stamp + $urandom_range(1, 30);
        send_sample(x, y, z, clock_stamp,
                    ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000)));
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // Writes a fresh random value to each gain register.
    task automatic random_gains;
        logic [31:0] g [3];
        for (int r = 0; r < 3; r++)
            g[r] = ($urandom_range(0, 3) == 0) ? $urandom
                                               : 32'($signed($urandom_range(0, 262144)) - 131072);
        write_gain(REG_PROP, g[0]);
        write_gain(REG_INTEG, g[1]);
        write_gain(REG_DERIV, g[2]);
    endtask

    initial begin
        int burst;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: warm-up with positive gains, then extremes of every field.
        write_gain(REG_PROP, 32'h0001_0000);
        write_gain(REG_INTEG, 32'h0000_8000);
        write_gain(REG_DERIV, 32'h0000_4000);
        send_sample(24'd0, 24'd0, 24'd0, 32'd0, 16'd0);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'd10, 16'd0);
        send_sample(24'h800000, 24'h800000, 24'h800000, 32'd20, 16'hFFFF);
        send_sample(24'd256, 24'd0, 24'd0, 32'd30, 16'd1000);
        send_sample(24'd0, 24'h800000, 24'd0, 32'd40, 16'd500);
        send_sample(24'd100, 24'd100, 24'd100, 32'd50, 16'd3000);
        send_sample(24'd100, 24'd50, 24'd0, 32'd50, 16'd2000);
        send_sample(24'd0, 24'd0, 24'd10, 32'd45, 16'hFFFF);
        send_sample(24'hFFFFFF, 24'd0, 24'd0, 32'hFFFF_FFFF, 16'd0);
        send_sample(24'd0, 24'd0, 24'd0, 32'd0, 16'hFFFF);
        send_sample(24'h555555, 24'hAAAAAA, 24'h123456, 32'hAAAA_5555, 16'h5555);
        send_sample(24'h2AAAAA, 24'h555555, 24'h654321, 32'h5555_AAAA, 16'hAAAA);
        in_valid <= 1'b0;
        drain();
        write_gain(REG_PROP, 32'h7FFF_FFFF);
        write_gain(REG_INTEG, 32'h8000_0000);
        write_gain(REG_DERIV, 32'h7FFF_FFFF);
        send_sample(24'd0, 24'd0, 24'd0, 32'd1, 16'hFFFF);
        send_sample(24'h7FFFFF, 24'd0, 24'd0, 32'hFFFF_FFFF, 16'd0);
        send_sample(24'd0, 24'd0, 24'd0, 32'd0, 16'hFFFF);
        in_valid <= 1'b0;
        drain();
        write_gain(REG_PROP, 32'h8000_0000);
        write_gain(REG_INTEG, 32'h0);
        write_gain(REG_DERIV, 32'h8000_0000);
        send_sample(24'd10, 24'd0, 24'd0, 32'd5, 16'd0);
        send_sample(24'd0, 24'd0, 24'd0, 32'd6, 16'd100);

        // Long hold on the receiver, timed on its own, while samples keep coming.
        fork
            begin
                long_hold <= 1'b1;
                repeat (400) @(negedge clk);
                long_hold <= 1'b0;
            end
            begin
                for (int n = 0; n < 6; n++) send_random();
                in_valid <= 1'b0;
            end
        join
        drain();

        // Random phases, each with its own gains.
        for (int ph = 0; ph < 8; ph++) begin
            random_gains();
            for (int n = 0; n < 100; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 100; b++, n++) send_random();
                if ($urandom_range(0, 2) != 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 120)) @(negedge clk);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
